### hdl/assert_macros.svh
// Assertion macros for the checker module of the color converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

### hdl/hsl2rgb_pkg.sv
// Constants and types for the HSL to RGB color converter.
// No dependencies; used by the converter and its checker.
package hsl2rgb_pkg;

   localparam int unsigned ONE_Q16         = 65536;
   localparam int unsigned HUE_FULL        = 36000;
   localparam int unsigned HUE_SECTOR      = 6000;
   localparam int unsigned HUE_BIAS        = 8424000;
   localparam int unsigned HUE_RECIP       = 1864;
   localparam int unsigned HUE_RECIP_SHIFT = 26;
   localparam int unsigned X_RECIP         = 89478;
   localparam int unsigned X_RECIP_SHIFT   = 29;

   typedef enum logic [2:0] {
      SECTOR_RED_YEL,
      SECTOR_YEL_GRN,
      SECTOR_GRN_CYN,
      SECTOR_CYN_BLU,
      SECTOR_BLU_MAG,
      SECTOR_MAG_RED
   } sector_type;

endpackage

### hdl/hsl_to_rgb_converter.sv
// HSL to RGB color converter, seven register stages.
// Depends on hsl2rgb_pkg.
//
// Each request carries a hue in hundredths of a degree and a saturation and
// lightness in Q1.16; each response carries red, green and blue in Q1.16,
// clamped to 0..1. The block takes one request per clock unless it stalls
// the request side, and answers requests in order. Its multipliers are the
// reciprocal step of the hue wrap, the wrap and chroma products, the
// hue-weight product, and the reciprocal step of the division by sixty
// degrees and its correction product. Every stage holds its request while
// the one after it is full and stalled, so empty stages still fill and a
// stalled response does not hold up requests until the whole pipeline is full.
module hsl_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_hue_centideg,
   input  logic [16:0] req_sat,
   input  logic [16:0] req_light,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [16:0] rsp_red,
   output logic [16:0] rsp_green,
   output logic [16:0] rsp_blue
);
   import hsl2rgb_pkg::*;

   localparam int unsigned STAGES = 7;

   function automatic logic [16:0] chan_clamp(input logic [16:0] c,
                                              input logic signed [17:0] m);
      logic signed [18:0] sum;
      sum = $signed({2'b00, c}) + $signed({m[17], m});
      if (sum < 0) begin
         return '0;
      end else if (sum > $signed(19'(ONE_Q16))) begin
         return 17'(ONE_Q16);
      end else begin
         return sum[16:0];
      end
   endfunction

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] adv;

   always_comb begin
      adv[STAGES-1] = !vld_ff[STAGES-1] || !rsp_stall;
      for (int k = STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in = {vld_ff[STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = vld_ff[STAGES-1];

   // Stage 1: bias the hue positive, estimate the quotient by 36000, clamp S and L.
   logic [25:0] hue_sum;
   logic [35:0] hue_recip_prod;
   logic [24:0] s1_bias_ff;
   logic [8:0]  s1_quot_ff;
   logic [16:0] s1_sat_ff;
   logic [16:0] s1_light_ff;
   logic [24:0] s1_bias_in;
   logic [8:0]  s1_quot_in;
   logic [16:0] s1_sat_in;
   logic [16:0] s1_light_in;

   always_comb begin
      hue_sum        = {{2{req_hue_centideg[23]}}, req_hue_centideg} + 26'(HUE_BIAS);
      s1_bias_in     = hue_sum[24:0];
      hue_recip_prod = 36'(s1_bias_in) * 36'(HUE_RECIP);
      s1_quot_in     = 9'(hue_recip_prod >> HUE_RECIP_SHIFT);
      s1_sat_in      = (req_sat > 17'(ONE_Q16)) ? 17'(ONE_Q16) : req_sat;
      s1_light_in    = (req_light > 17'(ONE_Q16)) ? 17'(ONE_Q16) : req_light;
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_bias_ff  <= s1_bias_in;
         s1_quot_ff  <= s1_quot_in;
         s1_sat_ff   <= s1_sat_in;
         s1_light_ff <= s1_light_in;
      end
   end

   // Stage 2: finish the hue wrap and form chroma.
   logic [24:0] hue_sub;
   logic [24:0] hue_rem;
   logic [17:0] light_dbl;
   logic [17:0] light_dist;
   logic [17:0] light_span;
   logic [33:0] chroma_prod;
   logic [15:0] s2_hue_ff;
   logic [16:0] s2_chroma_ff;
   logic [16:0] s2_light_ff;
   logic [15:0] s2_hue_in;
   logic [16:0] s2_chroma_in;

   always_comb begin
      hue_sub   = 25'(s1_quot_ff) * 25'(HUE_FULL);
      hue_rem   = s1_bias_ff - hue_sub;
      s2_hue_in = (hue_rem >= 25'(HUE_FULL)) ? 16'(hue_rem - 25'(HUE_FULL))
                                             : 16'(hue_rem);
      light_dbl  = {s1_light_ff, 1'b0};
      light_dist = (light_dbl >= 18'(ONE_Q16)) ? light_dbl - 18'(ONE_Q16)
                                               : 18'(ONE_Q16) - light_dbl;
      light_span   = 18'(ONE_Q16) - light_dist;
      chroma_prod  = 34'(light_span) * 34'(s1_sat_ff);
      s2_chroma_in = chroma_prod[32:16];
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         s2_hue_ff    <= s2_hue_in;
         s2_chroma_ff <= s2_chroma_in;
         s2_light_ff  <= s1_light_ff;
      end
   end

   // Stage 3: sector and the hue weight of the second component.
   logic [13:0] hue_pair;
   logic [12:0] hue_dist;
   logic [12:0] s3_weight_ff;
   sector_type  s3_sector_ff;
   logic [16:0] s3_chroma_ff;
   logic [16:0] s3_light_ff;
   logic [12:0] s3_weight_in;
   sector_type  s3_sector_in;

   always_comb begin
      if (s2_hue_ff < 16'(HUE_SECTOR)) begin
         s3_sector_in = SECTOR_RED_YEL;
         hue_pair     = 14'(s2_hue_ff);
      end else if (s2_hue_ff < 16'(2 * HUE_SECTOR)) begin
         s3_sector_in = SECTOR_YEL_GRN;
         hue_pair     = 14'(s2_hue_ff);
      end else if (s2_hue_ff < 16'(3 * HUE_SECTOR)) begin
         s3_sector_in = SECTOR_GRN_CYN;
         hue_pair     = 14'(s2_hue_ff - 16'(2 * HUE_SECTOR));
      end else if (s2_hue_ff < 16'(4 * HUE_SECTOR)) begin
         s3_sector_in = SECTOR_CYN_BLU;
         hue_pair     = 14'(s2_hue_ff - 16'(2 * HUE_SECTOR));
      end else if (s2_hue_ff < 16'(5 * HUE_SECTOR)) begin
         s3_sector_in = SECTOR_BLU_MAG;
         hue_pair     = 14'(s2_hue_ff - 16'(4 * HUE_SECTOR));
      end else begin
         s3_sector_in = SECTOR_MAG_RED;
         hue_pair     = 14'(s2_hue_ff - 16'(4 * HUE_SECTOR));
      end
      hue_dist     = (hue_pair >= 14'(HUE_SECTOR)) ? 13'(hue_pair - 14'(HUE_SECTOR))
                                                   : 13'(14'(HUE_SECTOR) - hue_pair);
      s3_weight_in = 13'(HUE_SECTOR) - hue_dist;
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         s3_weight_ff <= s3_weight_in;
         s3_sector_ff <= s3_sector_in;
         s3_chroma_ff <= s2_chroma_ff;
         s3_light_ff  <= s2_light_ff;
      end
   end

   // Stage 4: weight chroma by hue and form the offset m.
   logic [29:0]        weight_prod;
   logic [28:0]        s4_prod_ff;
   sector_type         s4_sector_ff;
   logic [16:0]        s4_chroma_ff;
   logic signed [17:0] s4_mid_ff;
   logic [28:0]        s4_prod_in;
   logic signed [17:0] s4_mid_in;

   always_comb begin
      weight_prod = 30'(s3_chroma_ff) * 30'(s3_weight_ff);
      s4_prod_in  = weight_prod[28:0];
      s4_mid_in   = $signed({1'b0, s3_light_ff}) - $signed({2'b00, s3_chroma_ff[16:1]});
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         s4_prod_ff   <= s4_prod_in;
         s4_sector_ff <= s3_sector_ff;
         s4_chroma_ff <= s3_chroma_ff;
         s4_mid_ff    <= s4_mid_in;
      end
   end

   // Stage 5: quotient estimate of the division by sixty degrees.
   logic [45:0]        x_recip_prod;
   logic [28:0]        s5_prod_ff;
   logic [16:0]        s5_est_ff;
   sector_type         s5_sector_ff;
   logic [16:0]        s5_chroma_ff;
   logic signed [17:0] s5_mid_ff;
   logic [16:0]        s5_est_in;

   always_comb begin
      x_recip_prod = 46'(s4_prod_ff) * 46'(X_RECIP);
      s5_est_in    = 17'(x_recip_prod >> X_RECIP_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         s5_prod_ff   <= s4_prod_ff;
         s5_est_ff    <= s5_est_in;
         s5_sector_ff <= s4_sector_ff;
         s5_chroma_ff <= s4_chroma_ff;
         s5_mid_ff    <= s4_mid_ff;
      end
   end

   // Stage 6: the estimate is at most one short, so one compare corrects it.
   logic [28:0]        x_rem;
   logic [16:0]        s6_x_ff;
   sector_type         s6_sector_ff;
   logic [16:0]        s6_chroma_ff;
   logic signed [17:0] s6_mid_ff;
   logic [16:0]        s6_x_in;

   always_comb begin
      x_rem   = s5_prod_ff - 29'(s5_est_ff) * 29'(HUE_SECTOR);
      s6_x_in = s5_est_ff + 17'(x_rem >= 29'(HUE_SECTOR));
   end

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         s6_x_ff      <= s6_x_in;
         s6_sector_ff <= s5_sector_ff;
         s6_chroma_ff <= s5_chroma_ff;
         s6_mid_ff    <= s5_mid_ff;
      end
   end

   // Stage 7: place chroma and x by sector, add m and clamp.
   logic [16:0] red_base;
   logic [16:0] green_base;
   logic [16:0] blue_base;
   logic [16:0] rsp_red_ff;
   logic [16:0] rsp_green_ff;
   logic [16:0] rsp_blue_ff;

   always_comb begin
      red_base   = '0;
      green_base = '0;
      blue_base  = '0;
      case (s6_sector_ff)
         SECTOR_RED_YEL: begin
            red_base   = s6_chroma_ff;
            green_base = s6_x_ff;
         end
         SECTOR_YEL_GRN: begin
            red_base   = s6_x_ff;
            green_base = s6_chroma_ff;
         end
         SECTOR_GRN_CYN: begin
            green_base = s6_chroma_ff;
            blue_base  = s6_x_ff;
         end
         SECTOR_CYN_BLU: begin
            green_base = s6_x_ff;
            blue_base  = s6_chroma_ff;
         end
         SECTOR_BLU_MAG: begin
            red_base  = s6_x_ff;
            blue_base = s6_chroma_ff;
         end
         default: begin
            red_base  = s6_chroma_ff;
            blue_base = s6_x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[6]) begin
         rsp_red_ff   <= chan_clamp(red_base, s6_mid_ff);
         rsp_green_ff <= chan_clamp(green_base, s6_mid_ff);
         rsp_blue_ff  <= chan_clamp(blue_base, s6_mid_ff);
      end
   end

   assign rsp_red   = rsp_red_ff;
   assign rsp_green = rsp_green_ff;
   assign rsp_blue  = rsp_blue_ff;

endmodule

### hdl/hsl2rgb_checker.sv
// Port-level checker for the HSL to RGB color converter, bound to the top level.
// Depends on hsl2rgb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsl2rgb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [23:0] req_hue_centideg,
   input logic [16:0] req_sat,
   input logic [16:0] req_light,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [16:0] rsp_red,
   input logic [16:0] rsp_green,
   input logic [16:0] rsp_blue
);
   import hsl2rgb_pkg::*;

   logic [50:0] rsp_color;
   logic        rsp_in_range;

   assign rsp_color    = {rsp_red, rsp_green, rsp_blue};
   assign rsp_in_range = rsp_red <= 17'(ONE_Q16) && rsp_green <= 17'(ONE_Q16)
                         && rsp_blue <= 17'(ONE_Q16);

   `ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `ASSERT_NEXT(a_rsp_data_holds, clock, reset, rsp_valid && rsp_stall, $stable(rsp_color))
   `ASSERT_ALWAYS(a_rsp_in_range, clock, reset, !rsp_valid || rsp_in_range)
   `ASSERT_ALWAYS(a_no_stall_when_drained, clock, reset, rsp_valid || !req_stall)
   `ASSERT_ALWAYS(a_empty_after_reset, clock, reset, !$past(reset) || !rsp_valid)

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker u_hsl2rgb_checker (.*);

### tb/sv/hsl_to_rgb_checker.sv
`timescale 1ns / 100ps
// Response checker for the HSL to RGB converter. It predicts the color of every
// accepted request and compares each accepted response with the oldest prediction.
// Depends on hsl2rgb_pkg for the hue and fixed-point constants and the sector type.
module hsl_to_rgb_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [23:0] req_hue_centideg,
   input  logic [16:0] req_sat,
   input  logic [16:0] req_light,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [16:0] rsp_red,
   input  logic [16:0] rsp_green,
   input  logic [16:0] rsp_blue,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);
   import hsl2rgb_pkg::*;

   localparam longint UNIT     = longint'(ONE_Q16);
   localparam longint HUE_WRAP = longint'(HUE_FULL);
   localparam longint SIXTY    = longint'(HUE_SECTOR);

   typedef struct packed {
      logic [16:0] red;
      logic [16:0] green;
      logic [16:0] blue;
   } rgb_type;

   rgb_type rgb_pending_q[$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
   end

   function automatic longint clamp_unit(longint level);
      if (level < 0) begin
         return 0;
      end
      if (level > UNIT) begin
         return UNIT;
      end
      return level;
   endfunction

   function automatic rgb_type convert_hsl(logic [23:0] hue, logic [16:0] sat,
                                           logic [16:0] light);
      longint     h;
      longint     s;
      longint     l;
      longint     f;
      longint     chroma;
      longint     t;
      longint     x;
      longint     m;
      longint     r1;
      longint     g1;
      longint     b1;
      sector_type sector;
      rgb_type    rgb;

      h = longint'(signed'(hue)) % HUE_WRAP;
      if (h < 0) begin
         h += HUE_WRAP;
      end
      s = longint'(sat);
      if (s > UNIT) begin
         s = UNIT;
      end
      l = longint'(light);
      if (l > UNIT) begin
         l = UNIT;
      end

      f = 2 * l - UNIT;
      if (f < 0) begin
         f = -f;
      end
      f = UNIT - f;
      chroma = (f * s) >>> 16;

      t = (h % (2 * SIXTY)) - SIXTY;
      if (t < 0) begin
         t = -t;
      end
      x = (chroma * (SIXTY - t)) / SIXTY;
      m = l - (chroma >>> 1);

      r1 = 0;
      g1 = 0;
      b1 = 0;
      sector = sector_type'(h / SIXTY);
      case (sector)
         SECTOR_RED_YEL: begin
            r1 = chroma;
            g1 = x;
         end
         SECTOR_YEL_GRN: begin
            r1 = x;
            g1 = chroma;
         end
         SECTOR_GRN_CYN: begin
            g1 = chroma;
            b1 = x;
         end
         SECTOR_CYN_BLU: begin
            g1 = x;
            b1 = chroma;
         end
         SECTOR_BLU_MAG: begin
            r1 = x;
            b1 = chroma;
         end
         default: begin
            r1 = chroma;
            b1 = x;
         end
      endcase

      rgb.red   = 17'(clamp_unit(r1 + m));
      rgb.green = 17'(clamp_unit(g1 + m));
      rgb.blue  = 17'(clamp_unit(b1 + m));
      return rgb;
   endfunction

   task automatic check_channel(input string channel, input logic [16:0] want,
                                input logic [16:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, channel, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rgb_type want;

      if (!reset) begin
         if (req_valid && !req_stall) begin
            rgb_pending_q.push_back(convert_hsl(req_hue_centideg, req_sat, req_light));
         end
         if (rsp_valid && !rsp_stall) begin
            if (rgb_pending_q.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %0d %0d %0d",
                        $time, rsp_red, rsp_green, rsp_blue);
               fail_count++;
            end else begin
               want = rgb_pending_q.pop_front();
               check_channel("red", want.red, rsp_red);
               check_channel("green", want.green, rsp_green);
               check_channel("blue", want.blue, rsp_blue);
               checked_count <= checked_count + 1;
            end
         end
         pending_count <= rgb_pending_q.size();
      end
   end

endmodule

### tb/sv/tb_hsl_to_rgb_converter.sv
`timescale 1ns / 100ps
// Testbench top for the HSL to RGB converter: drives corner and random colors
// with bursty requests and response stalls, and reports the verdict.
// Depends on hsl_to_rgb_converter and hsl_to_rgb_checker.
module tb_hsl_to_rgb_converter;

   localparam int RANDOM_REQUESTS = 1850;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic [23:0] req_hue_centideg = '0;
   logic [16:0] req_sat          = '0;
   logic [16:0] req_light        = '0;
   logic        rsp_stall        = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [16:0] rsp_red;
   logic [16:0] rsp_green;
   logic [16:0] rsp_blue;

   int fail_count;
   int pending_count;
   int checked_count;
   int sent_count = 0;

   hsl_to_rgb_converter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hue_centideg (req_hue_centideg),
      .req_sat          (req_sat),
      .req_light        (req_light),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue)
   );

   hsl_to_rgb_checker rgb_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_hue_centideg (req_hue_centideg),
      .req_sat          (req_sat),
      .req_light        (req_light),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .fail_count       (fail_count),
      .pending_count    (pending_count),
      .checked_count    (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   task automatic offer_color(input int hue, input int sat, input int light);
      req_valid        <= 1'b1;
      req_hue_centideg <= 24'(hue);
      req_sat          <= 17'(sat);
      req_light        <= 17'(light);
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   // The receiver also takes one long break, so the pipeline backs up to the input.
   initial begin
      int span;
      int mode;
      int cycle_count;
      bit held_off;

      cycle_count = 0;
      held_off    = 1'b0;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!held_off && cycle_count >= 300) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (100) @(posedge clock);
            cycle_count += 100;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            repeat (span) begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= 1'($urandom_range(0, 1));
                  2: rsp_stall <= ($urandom_range(0, 9) < 7);
                  default: rsp_stall <= cycle_count[1];
               endcase
               @(posedge clock);
               cycle_count++;
            end
         end
      end
   end

   initial begin
      int          burst;
      int          gap;
      int          drain;
      int          random_start;
      logic [23:0] hue;
      logic [16:0] sat;
      logic [16:0] light;
      bit          drained;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      offer_color(0, 65536, 32768);
      offer_color(5999, 65536, 32768);
      offer_color(6000, 65536, 32768);
      offer_color(11999, 65536, 32768);
      offer_color(12000, 65536, 32768);
      offer_color(18000, 65536, 32768);
      offer_color(24000, 65536, 32768);
      offer_color(30000, 65536, 32768);
      offer_color(35999, 65536, 32768);
      offer_color(36000, 65536, 32768);
      offer_color(-1, 65536, 32768);
      offer_color(-36000, 40000, 20000);
      offer_color(8388607, 65536, 50000);
      offer_color(-8388608, 65536, 10000);
      offer_color(3000, 0, 32768);
      offer_color(3000, 65536, 0);
      offer_color(3000, 65536, 65536);
      offer_color(15000, 131071, 32768);
      offer_color(27000, 65536, 131071);
      offer_color(27000, 131071, 131071);
      offer_color(21000, 65535, 1);
      offer_color(9000, 1, 65535);
      offer_color(3000, 65536, 32767);
      offer_color(33000, 43690, 32769);

      // Let the pipeline run dry before the random traffic starts.
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_count != 0);

      random_start = sent_count;
      while (sent_count - random_start < RANDOM_REQUESTS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            case ($urandom_range(0, 3))
               0: hue = 24'($urandom);
               1: hue = 24'($urandom_range(0, 35999));
               2: hue = 24'(6000 * $urandom_range(0, 6) + $urandom_range(0, 4) - 2);
               default: hue = 24'(-$urandom_range(1, 100000));
            endcase
            case ($urandom_range(0, 3))
               0: sat = 17'($urandom);
               1: sat = 17'($urandom_range(0, 65536));
               2: sat = 17'(32768 + $urandom_range(0, 8) - 4);
               default: sat = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            endcase
            case ($urandom_range(0, 3))
               0: light = 17'($urandom);
               1: light = 17'($urandom_range(0, 65536));
               2: light = 17'(32768 + $urandom_range(0, 8) - 4);
               default: light = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            endcase
            offer_color(int'(hue), int'(sat), int'(light));
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (pending_count != 0 && drain < 5000);
      drained = (pending_count == 0);
      if (!drained) begin
         $display("%0t: %0d expected responses never arrived", $time, pending_count);
      end
      repeat (30) @(posedge clock);

      $display("Sent %0d colors: sector edges, wrapped and negative hues, levels above one,",
               sent_count);
      $display("random colors, under bursty requests and stalls; %0d responses checked.",
               checked_count);
      if (drained && fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
